// ===== sv/sfr_pkg.sv =====
`timescale 1ns / 1ps

package sfr_pkg;

	// Fixed field widths
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned LEN_W   = 7;
	localparam int unsigned PARAM_W = 6;
	localparam int unsigned TRL_W   = 2;

	// Trailer: CRC low, CRC high, end code
	localparam int unsigned TRAILER_BYTES = 3;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_HEAD_CODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PARAM = 2'd1;
	localparam logic [PARAM_W-1:0]   MAX_PARAM_RESET = 6'd55;

	// Receive phase
	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HEADER,
		PH_PARAM,
		PH_TRAILER
	} phase_t;

	// Readout sequencer
	typedef enum logic [1:0] {
		DS_IDLE,
		DS_READ,
		DS_LOAD
	} dump_st_t;

	// Request from the receive side to read a finished frame out
	typedef struct packed {
		logic             start;
		logic [LEN_W-1:0] count;
	} dump_req_t;

endpackage

// ===== sv/sfr_in_if.sv =====
`timescale 1ns / 1ps

interface sfr_in_if
	import sfr_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== sv/sfr_out_if.sv =====
`timescale 1ns / 1ps

interface sfr_out_if
	import sfr_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] frame_byte;
	logic [LEN_W-1:0]  frame_length;
	logic              frame_last;

	modport source (output valid, output frame_byte, output frame_length, output frame_last,
		input ready);
	modport sink (input valid, input frame_byte, input frame_length, input frame_last,
		output ready);
endinterface

// ===== sv/sfr_ram.sv =====
`timescale 1ns / 1ps

module sfr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/sfr_rx.sv =====
`timescale 1ns / 1ps

module sfr_rx
	import sfr_pkg::*;
#(
	parameter int unsigned FRAME_DEPTH  = 64,
	parameter int unsigned LENGTH_INDEX = 5
) (
	input  logic                             clk,
	input  logic                             arst_n,
	sfr_in_if.sink                           in_ch,
	input  logic [BYTE_W-1:0]                head_code,
	input  logic [PARAM_W-1:0]               max_param_bytes,
	input  logic                             busy,
	output logic                             wr_en,
	output logic [$clog2(FRAME_DEPTH)-1:0]   wr_addr,
	output logic [BYTE_W-1:0]                wr_data,
	output dump_req_t                        dump_req
);

	localparam int unsigned AW = $clog2(FRAME_DEPTH);
	localparam int unsigned CW = $clog2(FRAME_DEPTH + 1);

	phase_t             phase_q, phase_d;
	logic [CW-1:0]      stored_q, stored_d;
	logic [PARAM_W-1:0] param_q, param_d;
	logic [TRL_W-1:0]   trail_q, trail_d;
	logic [PARAM_W-1:0] len_q, len_d;

	logic               accept;
	logic               full;
	logic [CW-1:0]      stored_inc;
	logic [PARAM_W-1:0] param_inc;
	logic [TRL_W-1:0]   trail_inc;
	logic [BYTE_W-1:0]  b;

	// No new byte while a frame is being read out of the store
	assign in_ch.ready = !busy;
	assign accept      = in_ch.valid && in_ch.ready;
	assign b           = in_ch.rx_byte;
	assign full        = stored_q >= CW'(FRAME_DEPTH);
	assign stored_inc  = stored_q + CW'(1);
	assign param_inc   = param_q + PARAM_W'(1);
	assign trail_inc   = trail_q + TRL_W'(1);

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			stored_q <= '0;
			param_q  <= '0;
			trail_q  <= '0;
			len_q    <= '0;
		end else begin
			phase_q  <= phase_d;
			stored_q <= stored_d;
			param_q  <= param_d;
			trail_q  <= trail_d;
			len_q    <= len_d;
		end
	end

	// Frame parser: next state and store writes
	always_comb begin
		phase_d  = phase_q;
		stored_d = stored_q;
		param_d  = param_q;
		trail_d  = trail_q;
		len_d    = len_q;
		wr_en    = 1'b0;
		wr_addr  = stored_q[AW-1:0];
		wr_data  = b;
		dump_req = '0;
		if (accept) begin
			unique case (phase_q)
				PH_IDLE: begin
					if (b == head_code) begin
						wr_en    = 1'b1;
						wr_addr  = '0;
						stored_d = CW'(1);
						param_d  = '0;
						trail_d  = '0;
						phase_d  = PH_HEADER;
					end
				end
				PH_HEADER: begin
					if (b == head_code && stored_q == CW'(1)) begin
						// repeated head byte in second position: skipped
					end else if (full) begin
						phase_d = PH_IDLE;
						param_d = '0;
						trail_d = '0;
					end else begin
						wr_en    = 1'b1;
						stored_d = stored_inc;
						if (stored_q == CW'(LENGTH_INDEX)) begin
							len_d = b[PARAM_W-1:0];
							if (b > {{(BYTE_W-PARAM_W){1'b0}}, max_param_bytes}) begin
								phase_d = PH_IDLE;
								param_d = '0;
								trail_d = '0;
							end else if (b != '0) begin
								phase_d = PH_PARAM;
							end else begin
								phase_d = PH_TRAILER;
							end
						end
					end
				end
				PH_PARAM: begin
					if (full) begin
						phase_d = PH_IDLE;
						param_d = '0;
						trail_d = '0;
					end else begin
						wr_en    = 1'b1;
						stored_d = stored_inc;
						if (param_inc > max_param_bytes) begin
							phase_d = PH_IDLE;
							param_d = '0;
							trail_d = '0;
						end else if (param_inc >= len_q) begin
							phase_d = PH_TRAILER;
							param_d = '0;
						end else begin
							param_d = param_inc;
						end
					end
				end
				PH_TRAILER: begin
					if (full) begin
						phase_d = PH_IDLE;
						param_d = '0;
						trail_d = '0;
					end else begin
						wr_en    = 1'b1;
						stored_d = stored_inc;
						if (trail_inc >= TRL_W'(TRAILER_BYTES)) begin
							// frame complete: hand it to the readout
							dump_req.start = 1'b1;
							dump_req.count = LEN_W'(stored_inc);
							phase_d        = PH_IDLE;
							param_d        = '0;
							trail_d        = '0;
						end else begin
							trail_d = trail_inc;
						end
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	// Checks
	a_start_from_trailer: assert property (@(posedge clk) disable iff (!arst_n)
		dump_req.start |-> (phase_q == PH_TRAILER && accept))
		else $error("readout started outside trailer phase");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		stored_q <= CW'(FRAME_DEPTH))
		else $error("stored byte count beyond store depth");

	a_no_write_in_readout: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !busy)
		else $error("store written during readout");

endmodule

// ===== sv/sfr_dump.sv =====
`timescale 1ns / 1ps

module sfr_dump
	import sfr_pkg::*;
#(
	parameter int unsigned FRAME_DEPTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dump_req_t                      dump_req,
	output logic                           busy,
	output logic                           rd_en,
	output logic [$clog2(FRAME_DEPTH)-1:0] rd_addr,
	input  logic [BYTE_W-1:0]              rd_data,
	sfr_out_if.source                      out_ch
);

	localparam int unsigned AW = $clog2(FRAME_DEPTH);

	dump_st_t          dstate_q, dstate_d;
	logic [AW-1:0]     idx_q, idx_d;
	logic [LEN_W-1:0]  cnt_q, cnt_d;
	logic              is_last;
	logic              load;

	logic              out_vld_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic [LEN_W-1:0]  out_len_q;
	logic              out_last_q;

	assign busy    = dstate_q != DS_IDLE;
	assign rd_addr = idx_q;
	assign is_last = (LEN_W'(idx_q) + LEN_W'(1)) == cnt_q;

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dstate_q <= DS_IDLE;
			idx_q    <= '0;
			cnt_q    <= '0;
		end else begin
			dstate_q <= dstate_d;
			idx_q    <= idx_d;
			cnt_q    <= cnt_d;
		end
	end

	// Read one byte, load it, repeat until the last one
	always_comb begin
		dstate_d = dstate_q;
		idx_d    = idx_q;
		cnt_d    = cnt_q;
		rd_en    = 1'b0;
		load     = 1'b0;
		unique case (dstate_q)
			DS_IDLE: begin
				if (dump_req.start) begin
					idx_d    = '0;
					cnt_d    = dump_req.count;
					dstate_d = DS_READ;
				end
			end
			DS_READ: begin
				// issue only when the output register is free next cycle
				if (!out_vld_q || out_ch.ready) begin
					rd_en    = 1'b1;
					dstate_d = DS_LOAD;
				end
			end
			DS_LOAD: begin
				load = 1'b1;
				if (is_last) begin
					dstate_d = DS_IDLE;
				end else begin
					idx_d    = idx_q + AW'(1);
					dstate_d = DS_READ;
				end
			end
			default: begin
				dstate_d = DS_IDLE;
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load) begin
			out_vld_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= rd_data;
			out_len_q  <= cnt_q;
			out_last_q <= is_last;
		end
	end

	assign out_ch.valid        = out_vld_q;
	assign out_ch.frame_byte   = out_byte_q;
	assign out_ch.frame_length = out_len_q;
	assign out_ch.frame_last   = out_last_q;

	// Checks
	a_load_into_empty: assert property (@(posedge clk) disable iff (!arst_n)
		dstate_q == DS_LOAD |-> !out_vld_q)
		else $error("output register overwritten before transaction");

	a_load_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		dstate_q == DS_LOAD |-> $past(rd_en))
		else $error("load without a preceding store read");

	a_start_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		dump_req.start |-> dstate_q == DS_IDLE)
		else $error("new frame while readout in progress");

endmodule

// ===== sv/serial_frame_receiver.sv =====
`timescale 1ns / 1ps

// Serial frame receiver.
// in_ch carries received UART bytes, one per transaction. The block hunts for
// the head byte, gathers header, parameter and trailer bytes into a frame
// store, and drops frames whose length byte exceeds max_param_bytes.
// When the last trailer byte is taken, the whole frame is played out on
// out_ch, one byte per transaction, each tagged with the frame length and a
// last flag on the final byte.
// Throughput: one input byte per cycle while receiving. A completed frame is
// read out one byte at a time through the single read port (store read,
// then output load); in_ch.ready is low for that time. A stall on out_ch
// holds the output register and pauses the store reads. Configuration
// (cfg_we/cfg_index/cfg_wdata) is written by the user only while idle; the
// block itself does not enforce this. Reset: back to hunting for the head
// byte, head_code = 0, max_param_bytes = 55; the frame store is not cleared
// and needs no sweep.
module serial_frame_receiver
	import sfr_pkg::*;
#(
	parameter int unsigned FRAME_DEPTH  = 64,
	parameter int unsigned LENGTH_INDEX = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	sfr_in_if.sink                in_ch,
	sfr_out_if.source             out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int unsigned AW = $clog2(FRAME_DEPTH);

	logic [BYTE_W-1:0]  head_code_q;
	logic [PARAM_W-1:0] max_param_q;

	logic               busy;
	dump_req_t          dump_req;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [BYTE_W-1:0]  wr_data;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic [BYTE_W-1:0]  rd_data;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_code_q <= '0;
			max_param_q <= MAX_PARAM_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_HEAD_CODE) begin
				head_code_q <= cfg_wdata[BYTE_W-1:0];
			end
			if (cfg_index == REG_MAX_PARAM) begin
				max_param_q <= cfg_wdata[PARAM_W-1:0];
			end
		end
	end

	// Frame parser
	sfr_rx #(
		.FRAME_DEPTH  (FRAME_DEPTH),
		.LENGTH_INDEX (LENGTH_INDEX)
	) u_rx (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_ch           (in_ch),
		.head_code       (head_code_q),
		.max_param_bytes (max_param_q),
		.busy            (busy),
		.wr_en           (wr_en),
		.wr_addr         (wr_addr),
		.wr_data         (wr_data),
		.dump_req        (dump_req)
	);

	// Frame store
	sfr_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (FRAME_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Frame readout
	sfr_dump #(
		.FRAME_DEPTH (FRAME_DEPTH)
	) u_dump (
		.clk      (clk),
		.arst_n   (arst_n),
		.dump_req (dump_req),
		.busy     (busy),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.out_ch   (out_ch)
	);

endmodule
